[design/efqt_pkg.sv]
// shared types, constants and crc function for the event frame queue transmitter
package efqt_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CRC_STEPS   = 11;
    localparam int STEP_W      = $clog2(CRC_STEPS);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  SOF_A    = 8'hAA;
    localparam logic [7:0]  SOF_B    = 8'h55;
    localparam logic [7:0]  LEN_BYTE = 8'd13;
    localparam logic [7:0]  EOF_BYTE = 8'h0D;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CRC   = 5'b00010,
        ST_WRITE = 5'b00100,
        ST_SEND  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic [7:0]  src;
        logic [3:0]  flag;
        logic [15:0] peak;
        logic [31:0] energy;
        logic [15:0] seq;
        logic [15:0] crc;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // one byte through crc16-ccitt, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[design/efqt_ram.sv]
// generic single-write, single-read ram with registered read data
module efqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[design/event_frame_queue_transmitter.sv]
// event framer with crc16 and a ring of queued frames sent one byte per tick
//
//  channel | signals                                               | handshake
//  --------+-------------------------------------------------------+-----------------
//  in      | cmd trig chan wave_end                                | in_valid/in_ready
//          | peak_sample energy                                    |
//  out     | accepted tx_valid tx_byte tx_last dropped_total       | out_valid/out_ready
//          | frames_pending                                        |
//  cfg     | cfg_wr_data (source id)                               | cfg_wr_en
//
//  queued event: crc passes from the length byte to the sequence number, then the ram write
//  tick with a queued frame: the send state picks the byte from the registered ram read
//  dropped event or tick on an empty queue: straight from idle to the done state
//  one word at a time; a finished word waits in the output register while the next is taken
//  reset clears pointers and counters and sets the source id to 1; ram contents are not cleared
module event_frame_queue_transmitter
    import efqt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic        trig,
    input  logic        chan,
    input  logic        wave_end,
    input  logic [15:0] peak_sample,
    input  logic [31:0] energy,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic [31:0] dropped_total,
    output logic [3:0]  frames_pending,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(QUEUE_DEPTH);
    localparam logic [STEP_W-1:0]  STEP_LAST  = STEP_W'(CRC_STEPS - 1);

    state_t state_reg, state_next;

    logic [PTR_W-1:0]   write_ptr_reg, write_ptr_next;
    logic [PTR_W-1:0]   read_ptr_reg, read_ptr_next;
    logic [COUNT_W-1:0] frame_count_reg, frame_count_next;
    logic [3:0]         byte_pos_reg, byte_pos_next;
    logic [31:0]        drop_total_reg, drop_total_next;
    logic               overflow_reg, overflow_next;
    logic [15:0]        seq_reg, seq_next;
    logic [7:0]         source_id_reg, source_id_next;

    logic [STEP_W-1:0]  step_reg, step_next;
    logic [15:0]        crc_reg, crc_next;
    logic [3:0]         flag_reg, flag_next;
    logic [15:0]        peak_reg, peak_next;
    logic [31:0]        energy_reg, energy_next;

    logic               res_acc_reg, res_acc_next;
    logic               res_txv_reg, res_txv_next;
    logic [7:0]         res_txb_reg, res_txb_next;
    logic               res_txl_reg, res_txl_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_acc_reg, out_acc_next;
    logic               out_txv_reg, out_txv_next;
    logic [7:0]         out_txb_reg, out_txb_next;
    logic               out_txl_reg, out_txl_next;
    logic [31:0]        out_drop_reg, out_drop_next;
    logic [3:0]         out_pend_reg, out_pend_next;

    logic               ram_wr_en;
    entry_t             ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_raw;
    entry_t             rd_entry;
    logic [7:0]         crc_in_byte;
    logic [7:0]         frame_byte;
    logic [COUNT_W+3:0] count_ext;
    logic               in_fire;
    logic               out_free;

    efqt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(write_ptr_reg),
        .wr_data(ram_wr_data),
        .rd_addr(read_ptr_reg),
        .rd_data(ram_rd_raw)
    );

    assign rd_entry  = entry_t'(ram_rd_raw);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign count_ext = {4'b0000, frame_count_reg};

    assign ram_wr_en   = (state_reg == ST_WRITE);
    assign ram_wr_data = '{src: source_id_reg, flag: flag_reg, peak: peak_reg,
                           energy: energy_reg, seq: seq_reg, crc: crc_reg};

    // byte fed to the crc unit on each pass
    always_comb
    begin
        case (step_reg)
            STEP_W'(0):  crc_in_byte = LEN_BYTE;
            STEP_W'(1):  crc_in_byte = source_id_reg;
            STEP_W'(2):  crc_in_byte = {4'b0000, flag_reg};
            STEP_W'(3):  crc_in_byte = peak_reg[15:8];
            STEP_W'(4):  crc_in_byte = peak_reg[7:0];
            STEP_W'(5):  crc_in_byte = energy_reg[31:24];
            STEP_W'(6):  crc_in_byte = energy_reg[23:16];
            STEP_W'(7):  crc_in_byte = energy_reg[15:8];
            STEP_W'(8):  crc_in_byte = energy_reg[7:0];
            STEP_W'(9):  crc_in_byte = seq_reg[15:8];
            default:     crc_in_byte = seq_reg[7:0];
        endcase
    end

    // frame byte of the oldest entry
    always_comb
    begin
        case (byte_pos_reg)
            4'd0:    frame_byte = SOF_A;
            4'd1:    frame_byte = SOF_B;
            4'd2:    frame_byte = LEN_BYTE;
            4'd3:    frame_byte = rd_entry.src;
            4'd4:    frame_byte = {4'b0000, rd_entry.flag};
            4'd5:    frame_byte = rd_entry.peak[15:8];
            4'd6:    frame_byte = rd_entry.peak[7:0];
            4'd7:    frame_byte = rd_entry.energy[31:24];
            4'd8:    frame_byte = rd_entry.energy[23:16];
            4'd9:    frame_byte = rd_entry.energy[15:8];
            4'd10:   frame_byte = rd_entry.energy[7:0];
            4'd11:   frame_byte = rd_entry.seq[15:8];
            4'd12:   frame_byte = rd_entry.seq[7:0];
            4'd13:   frame_byte = rd_entry.crc[15:8];
            4'd14:   frame_byte = rd_entry.crc[7:0];
            default: frame_byte = EOF_BYTE;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        write_ptr_next   = write_ptr_reg;
        read_ptr_next    = read_ptr_reg;
        frame_count_next = frame_count_reg;
        byte_pos_next    = byte_pos_reg;
        drop_total_next  = drop_total_reg;
        overflow_next    = overflow_reg;
        seq_next         = seq_reg;
        source_id_next   = source_id_reg;
        step_next        = step_reg;
        crc_next         = crc_reg;
        flag_next        = flag_reg;
        peak_next        = peak_reg;
        energy_next      = energy_reg;
        res_acc_next     = res_acc_reg;
        res_txv_next     = res_txv_reg;
        res_txb_next     = res_txb_reg;
        res_txl_next     = res_txl_reg;
        out_valid_next   = out_valid_reg;
        out_acc_next     = out_acc_reg;
        out_txv_next     = out_txv_reg;
        out_txb_next     = out_txb_reg;
        out_txl_next     = out_txl_reg;
        out_drop_next    = out_drop_reg;
        out_pend_next    = out_pend_reg;

        if (cfg_wr_en)
        begin
            source_id_next = cfg_wr_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_acc_next = 1'b0;
                    res_txv_next = 1'b0;
                    res_txb_next = 8'h00;
                    res_txl_next = 1'b0;
                    if (!cmd)
                    begin
                        if (frame_count_reg == COUNT_FULL)
                        begin
                            drop_total_next = drop_total_reg + 32'd1;
                            overflow_next   = 1'b1;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            flag_next   = {overflow_reg, wave_end, chan, trig};
                            peak_next   = peak_sample;
                            energy_next = energy;
                            step_next   = '0;
                            crc_next    = CRC_INIT;
                            state_next  = ST_CRC;
                        end
                    end
                    else if (frame_count_reg == '0)
                    begin
                        byte_pos_next = 4'd0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SEND;
                    end
                end
            end

            ST_CRC:
            begin
                crc_next  = crc_byte(crc_reg, crc_in_byte);
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                write_ptr_next   = (write_ptr_reg == PTR_LAST) ? '0 : write_ptr_reg + 1'b1;
                frame_count_next = frame_count_reg + 1'b1;
                overflow_next    = 1'b0;
                seq_next         = seq_reg + 16'd1;
                res_acc_next     = 1'b1;
                state_next       = ST_DONE;
            end

            ST_SEND:
            begin
                res_txv_next = 1'b1;
                res_txb_next = frame_byte;
                if (byte_pos_reg == 4'd15)
                begin
                    res_txl_next     = 1'b1;
                    byte_pos_next    = 4'd0;
                    read_ptr_next    = (read_ptr_reg == PTR_LAST) ? '0 : read_ptr_reg + 1'b1;
                    frame_count_next = frame_count_reg - 1'b1;
                end
                else
                begin
                    byte_pos_next = byte_pos_reg + 4'd1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = res_acc_reg;
                    out_txv_next   = res_txv_reg;
                    out_txb_next   = res_txb_reg;
                    out_txl_next   = res_txl_reg;
                    out_drop_next  = drop_total_reg;
                    out_pend_next  = count_ext[3:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            write_ptr_reg   <= '0;
            read_ptr_reg    <= '0;
            frame_count_reg <= '0;
            byte_pos_reg    <= 4'd0;
            drop_total_reg  <= 32'd0;
            overflow_reg    <= 1'b0;
            seq_reg         <= 16'd0;
            source_id_reg   <= 8'd1;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            write_ptr_reg   <= write_ptr_next;
            read_ptr_reg    <= read_ptr_next;
            frame_count_reg <= frame_count_next;
            byte_pos_reg    <= byte_pos_next;
            drop_total_reg  <= drop_total_next;
            overflow_reg    <= overflow_next;
            seq_reg         <= seq_next;
            source_id_reg   <= source_id_next;
            step_reg        <= step_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        flag_reg     <= flag_next;
        peak_reg     <= peak_next;
        energy_reg   <= energy_next;
        res_acc_reg  <= res_acc_next;
        res_txv_reg  <= res_txv_next;
        res_txb_reg  <= res_txb_next;
        res_txl_reg  <= res_txl_next;
        out_acc_reg  <= out_acc_next;
        out_txv_reg  <= out_txv_next;
        out_txb_reg  <= out_txb_next;
        out_txl_reg  <= out_txl_next;
        out_drop_reg <= out_drop_next;
        out_pend_reg <= out_pend_next;
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = out_acc_reg;
    assign tx_valid       = out_txv_reg;
    assign tx_byte        = out_txb_reg;
    assign tx_last        = out_txl_reg;
    assign dropped_total  = out_drop_reg;
    assign frames_pending = out_pend_reg;

endmodule
